[hw/rtl/char_lcd_nibble_sequencer_unit_defines.svh]
// Assertion macros used by the character LCD sequencer RTL
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_UNIT_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CLCD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("clcd assertion failed");

// next-cycle implication, checked outside reset
`define CLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("clcd assertion failed");

`endif

[hw/rtl/clcd_pkg.sv]
// Types, constants and sequence tables for the character LCD sequencer
`timescale 1ns / 1ps
package clcd_pkg;

    localparam int MODE_W    = 3;
    localparam int BYTE_W    = 8;
    localparam int NIB_W     = 4;
    localparam int HOLD_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PC_W      = 4;
    localparam int SUB_W     = 3;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = 1;
    localparam int QCNT_W    = 2;

    // request modes
    localparam logic [MODE_W-1:0] MODE_CMD   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DATA  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_NIB   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INIT  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_HOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_UP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_LONG   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_SHORT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_WAIT  = 3'd4;

    localparam logic [HOLD_W-1:0] RST_PULSE_HOLD = 16'd5;
    localparam logic [HOLD_W-1:0] RST_POWER_UP   = 16'd40000;
    localparam logic [HOLD_W-1:0] RST_INIT_LONG  = 16'd5000;
    localparam logic [HOLD_W-1:0] RST_INIT_SHORT = 16'd120;
    localparam logic [HOLD_W-1:0] RST_CLEAR_WAIT = 16'd1000;

    // LCD command bytes and init nibbles
    localparam logic [BYTE_W-1:0] LCD_FUNC_SET    = 8'h28;
    localparam logic [BYTE_W-1:0] LCD_DISPLAY_OFF = 8'h08;
    localparam logic [BYTE_W-1:0] LCD_DISPLAY_ON  = 8'h0C;
    localparam logic [BYTE_W-1:0] LCD_ENTRY_MODE  = 8'h06;
    localparam logic [BYTE_W-1:0] LCD_CLEAR       = 8'h01;
    localparam logic [BYTE_W-1:0] INIT_WAKE_NIB   = 8'h03;
    localparam logic [BYTE_W-1:0] INIT_4BIT_NIB   = 8'h02;

    localparam logic [SUB_W-1:0] SUB_LAST_BYTE = 3'd4;
    localparam logic [SUB_W-1:0] SUB_LAST_NIB  = 3'd1;
    localparam logic [SUB_W-1:0] SUB_LAST_WAIT = 3'd0;

    typedef enum logic [2:0] {
        KIND_CMD,
        KIND_DATA,
        KIND_NIB,
        KIND_CLEAR,
        KIND_INIT
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] value;
    } t_job;

    typedef struct packed {
        logic [HOLD_W-1:0] pulse_hold_us;
        logic [HOLD_W-1:0] power_up_wait_us;
        logic [HOLD_W-1:0] init_long_wait_us;
        logic [HOLD_W-1:0] init_short_wait_us;
        logic [HOLD_W-1:0] clear_wait_us;
    } t_cfg;

    typedef enum logic [2:0] {
        OP_BYTE,
        OP_NIB,
        OP_POWER,
        OP_WAIT_LONG,
        OP_WAIT_SHORT,
        OP_WAIT_CLEAR
    } t_op;

    // one step of a job program; tail marks the final step
    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] value;
        logic              rs;
        logic              tail;
    } t_macro;

    typedef struct packed {
        logic [NIB_W-1:0]  data_nibble;
        logic              reg_select;
        logic              enable;
        logic [HOLD_W-1:0] hold_us;
        logic              last;
    } t_pin;

    function automatic t_macro mk(t_op op, logic [BYTE_W-1:0] value, logic rs, logic tail);
        t_macro m;
        m.op    = op;
        m.value = value;
        m.rs    = rs;
        m.tail  = tail;
        return m;
    endfunction

    // program step pc of a job
    function automatic t_macro macro_at(t_kind kind, logic [PC_W-1:0] pc,
                                        logic [BYTE_W-1:0] value);
        t_macro m;
        m = mk(OP_WAIT_CLEAR, '0, 1'b0, 1'b1);
        unique case (kind)
            KIND_CMD:   m = mk(OP_BYTE, value, 1'b0, 1'b1);
            KIND_DATA:  m = mk(OP_BYTE, value, 1'b1, 1'b1);
            KIND_NIB:   m = mk(OP_NIB, {4'h0, value[NIB_W-1:0]}, 1'b0, 1'b1);
            KIND_CLEAR: begin
                if (pc == '0) m = mk(OP_BYTE, LCD_CLEAR, 1'b0, 1'b0);
                else          m = mk(OP_WAIT_CLEAR, '0, 1'b0, 1'b1);
            end
            KIND_INIT: begin
                unique case (pc)
                    4'd0:    m = mk(OP_POWER, '0, 1'b0, 1'b0);
                    4'd1:    m = mk(OP_NIB, INIT_WAKE_NIB, 1'b0, 1'b0);
                    4'd2:    m = mk(OP_WAIT_LONG, '0, 1'b0, 1'b0);
                    4'd3:    m = mk(OP_NIB, INIT_WAKE_NIB, 1'b0, 1'b0);
                    4'd4:    m = mk(OP_WAIT_SHORT, '0, 1'b0, 1'b0);
                    4'd5:    m = mk(OP_NIB, INIT_WAKE_NIB, 1'b0, 1'b0);
                    4'd6:    m = mk(OP_NIB, INIT_4BIT_NIB, 1'b0, 1'b0);
                    4'd7:    m = mk(OP_BYTE, LCD_FUNC_SET, 1'b0, 1'b0);
                    4'd8:    m = mk(OP_BYTE, LCD_DISPLAY_OFF, 1'b0, 1'b0);
                    4'd9:    m = mk(OP_BYTE, LCD_DISPLAY_ON, 1'b0, 1'b0);
                    4'd10:   m = mk(OP_BYTE, LCD_ENTRY_MODE, 1'b0, 1'b0);
                    4'd11:   m = mk(OP_BYTE, LCD_CLEAR, 1'b0, 1'b0);
                    default: m = mk(OP_WAIT_CLEAR, '0, 1'b0, 1'b1);
                endcase
            end
            default: m = mk(OP_WAIT_CLEAR, '0, 1'b0, 1'b1);
        endcase
        return m;
    endfunction

    function automatic logic [SUB_W-1:0] sub_last(t_op op);
        logic [SUB_W-1:0] s;
        unique case (op)
            OP_BYTE: s = SUB_LAST_BYTE;
            OP_NIB:  s = SUB_LAST_NIB;
            default: s = SUB_LAST_WAIT;
        endcase
        return s;
    endfunction

endpackage

[hw/rtl/clcd_req_if.sv]
// Request channel: mode and byte value with valid/ready
`timescale 1ns / 1ps
interface clcd_req_if;
    import clcd_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [BYTE_W-1:0]   byte_value;

    modport source (output valid, output mode, output byte_value, input ready);
    modport sink   (input valid, input mode, input byte_value, output ready);
endinterface

[hw/rtl/clcd_pin_if.sv]
// Pin state channel: LCD pin levels and hold time with valid/ready
`timescale 1ns / 1ps
interface clcd_pin_if;
    import clcd_pkg::*;

    logic                valid;
    logic                ready;
    logic [NIB_W-1:0]    data_nibble;
    logic                reg_select;
    logic                enable;
    logic [HOLD_W-1:0]   hold_us;
    logic                last;

    modport source (output valid, output data_nibble, output reg_select, output enable,
                    output hold_us, output last, input ready);
    modport sink   (input valid, input data_nibble, input reg_select, input enable,
                    input hold_us, input last, output ready);
endinterface

[hw/rtl/clcd_front.sv]
// Request front end: accepts requests, classifies the mode, drops unused modes
`timescale 1ns / 1ps
module clcd_front (
    clcd_req_if.sink        i_req,
    input  logic            i_q_full,
    output logic            o_push,
    output clcd_pkg::t_job  o_job
);
    import clcd_pkg::*;

    logic w_known;
    t_kind w_kind;

    always_comb begin
        w_known = 1'b1;
        w_kind  = KIND_CMD;
        unique case (i_req.mode)
            MODE_CMD:   w_kind = KIND_CMD;
            MODE_DATA:  w_kind = KIND_DATA;
            MODE_NIB:   w_kind = KIND_NIB;
            MODE_CLEAR: w_kind = KIND_CLEAR;
            MODE_INIT:  w_kind = KIND_INIT;
            default:    w_known = 1'b0;
        endcase
    end

    assign i_req.ready = !i_q_full;
    // unused modes complete their transfer but leave no job
    assign o_push      = i_req.valid && !i_q_full && w_known;
    assign o_job.kind  = w_kind;
    assign o_job.value = i_req.byte_value;

endmodule

[hw/rtl/clcd_fifo.sv]
// Two-entry job queue between front end and sequencer
`timescale 1ns / 1ps
module clcd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  clcd_pkg::t_job  i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output clcd_pkg::t_job  o_job
);
    import clcd_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_mem[r_wptr] <= i_job;
                r_wptr        <= r_wptr + 1'b1;
            end
            if (w_pop) r_rptr <= r_rptr + 1'b1;
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hw/rtl/clcd_back.sv]
// Pin sequencer: walks a job's program and emits one pin state per cycle while running and the output is taken
`timescale 1ns / 1ps
`include "char_lcd_nibble_sequencer_unit_defines.svh"
module clcd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  clcd_pkg::t_cfg  i_cfg,
    input  logic            i_q_valid,
    input  clcd_pkg::t_job  i_q_job,
    output logic            o_q_pop,
    clcd_pin_if.source      o_pin
);
    import clcd_pkg::*;

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state            r_state;
    t_kind             r_kind;
    logic [BYTE_W-1:0] r_val;
    logic [PC_W-1:0]   r_pc;
    logic [SUB_W-1:0]  r_sub;
    logic [NIB_W-1:0]  r_nib;
    logic              r_out_valid;
    t_pin              r_out;

    t_macro w_m;
    t_pin   w_pin;
    logic   w_sub_done;
    logic   w_slot_free;

    always_comb begin
        w_m          = macro_at(r_kind, r_pc, r_val);
        w_sub_done   = (r_sub == sub_last(w_m.op));
        w_pin.data_nibble = r_nib;
        w_pin.reg_select  = 1'b0;
        w_pin.enable      = 1'b0;
        w_pin.hold_us     = i_cfg.pulse_hold_us;
        unique case (w_m.op)
            OP_BYTE: begin
                // high nibble set, strobe, low nibble set, strobe, release
                unique case (r_sub)
                    3'd0, 3'd1: w_pin.data_nibble = w_m.value[BYTE_W-1:NIB_W];
                    default:    w_pin.data_nibble = w_m.value[NIB_W-1:0];
                endcase
                w_pin.reg_select = w_m.rs && (r_sub != SUB_LAST_BYTE);
                w_pin.enable     = r_sub[0];
            end
            OP_NIB: begin
                w_pin.data_nibble = w_m.value[NIB_W-1:0];
                w_pin.enable      = (r_sub == '0);
            end
            OP_POWER: begin
                w_pin.data_nibble = '0;
                w_pin.hold_us     = i_cfg.power_up_wait_us;
            end
            OP_WAIT_LONG:  w_pin.hold_us = i_cfg.init_long_wait_us;
            OP_WAIT_SHORT: w_pin.hold_us = i_cfg.init_short_wait_us;
            default:       w_pin.hold_us = i_cfg.clear_wait_us;
        endcase
        w_pin.last = w_sub_done && w_m.tail;
    end

    assign w_slot_free = !r_out_valid || o_pin.ready;
    assign o_q_pop     = (r_state == ST_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a new state fills the slot, otherwise a pending one stays until taken
            r_out_valid <= ((r_state == ST_RUN) && w_slot_free) ||
                           (r_out_valid && !o_pin.ready);
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_kind  <= i_q_job.kind;
                        r_val   <= i_q_job.value;
                        r_pc    <= '0;
                        r_sub   <= '0;
                        r_nib   <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (w_slot_free) begin
                        r_out       <= w_pin;
                        r_nib       <= w_pin.data_nibble;
                        if (w_sub_done) begin
                            r_sub <= '0;
                            r_pc  <= r_pc + 1'b1;
                        end else begin
                            r_sub <= r_sub + 1'b1;
                        end
                        if (w_pin.last) r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_pin.valid       = r_out_valid;
    assign o_pin.data_nibble = r_out.data_nibble;
    assign o_pin.reg_select  = r_out.reg_select;
    assign o_pin.enable      = r_out.enable;
    assign o_pin.hold_us     = r_out.hold_us;
    assign o_pin.last        = r_out.last;

    // a strobe phase always carries the pulse hold
    `CLCD_ASSERT_IMPL(a_strobe_hold, i_clk, i_rst_n, r_out_valid && r_out.enable, r_out.hold_us == i_cfg.pulse_hold_us)
    // a fetched job starts running at once
    `CLCD_ASSERT_NEXT(a_pop_runs, i_clk, i_rst_n, o_q_pop, r_state == ST_RUN)
    // phase counter never passes the byte's release phase
    `CLCD_ASSERT_IMPL(a_sub_range, i_clk, i_rst_n, r_state == ST_RUN, r_sub <= SUB_LAST_BYTE)

endmodule

[hw/rtl/char_lcd_nibble_sequencer_unit.sv]
// Top level of the character LCD 4-bit bus sequencer
`timescale 1ns / 1ps
// Turns each request into the run of LCD pin states (nibble, select, enable,
// hold time) that carries it out. The sequencer emits one pin state per cycle
// when the output is taken every cycle, and returns to idle between runs to
// fetch the next job from its two-entry queue. Requests with an unused mode
// (5 to 7) are taken and produce nothing. Timing registers are written through
// the plain write port; the user must write them only while no run is pending,
// as the block does not enforce this. Writes to indexes above 4 are ignored.
module char_lcd_nibble_sequencer_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [clcd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [clcd_pkg::HOLD_W-1:0]       i_cfg_wdata,
    clcd_req_if.sink                          i_req,
    clcd_pin_if.source                        o_pin
);
    import clcd_pkg::*;

    t_cfg r_cfg;
    logic w_push;
    t_job w_push_job;
    logic w_q_full;
    logic w_q_valid;
    t_job w_q_job;
    logic w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_hold_us      <= RST_PULSE_HOLD;
            r_cfg.power_up_wait_us   <= RST_POWER_UP;
            r_cfg.init_long_wait_us  <= RST_INIT_LONG;
            r_cfg.init_short_wait_us <= RST_INIT_SHORT;
            r_cfg.clear_wait_us      <= RST_CLEAR_WAIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PULSE_HOLD: r_cfg.pulse_hold_us      <= i_cfg_wdata;
                CFG_POWER_UP:   r_cfg.power_up_wait_us   <= i_cfg_wdata;
                CFG_INIT_LONG:  r_cfg.init_long_wait_us  <= i_cfg_wdata;
                CFG_INIT_SHORT: r_cfg.init_short_wait_us <= i_cfg_wdata;
                CFG_CLEAR_WAIT: r_cfg.clear_wait_us      <= i_cfg_wdata;
                default:        r_cfg <= r_cfg;
            endcase
        end
    end

    clcd_front u_front (
        .i_req    (i_req),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    clcd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_job   (w_q_job)
    );

    clcd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_q_job   (w_q_job),
        .o_q_pop   (w_q_pop),
        .o_pin     (o_pin)
    );

endmodule
